// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; take in with a plain include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/rqp_pkg.sv
// Package for the repeat quantifier parser: character codes, token classes,
// status codes and the token word passed from front to back. No dependencies.
package rqp_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int OUT_WIDTH       = 32;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam int         RADIX     = 10;

    typedef logic [2:0] tok_kind_t;
    localparam tok_kind_t TOK_EOT   = 3'd0;
    localparam tok_kind_t TOK_OPEN  = 3'd1;
    localparam tok_kind_t TOK_CLOSE = 3'd2;
    localparam tok_kind_t TOK_COMMA = 3'd3;
    localparam tok_kind_t TOK_SPACE = 3'd4;
    localparam tok_kind_t TOK_DIGIT = 3'd5;
    localparam tok_kind_t TOK_OTHER = 3'd6;

    typedef logic [1:0] status_t;
    localparam status_t ST_PENDING = 2'd0;
    localparam status_t ST_ACCEPT  = 2'd1;
    localparam status_t ST_ERROR   = 2'd2;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } token_t;

endpackage

// File: sv/rqp_front.sv
// Front end: classifies one input character into a token word.
// Depends on rqp_pkg.
module rqp_front (
    input  logic [7:0]      char_code,
    input  logic            end_of_text,
    output rqp_pkg::token_t token
);
    import rqp_pkg::*;

    logic [7:0] digit_val;

    assign digit_val = char_code - CH_ZERO;

    always_comb begin
        token.digit = digit_val[3:0];
        if (end_of_text) begin
            token.kind = TOK_EOT;
        end else if (char_code == CH_LBRACE) begin
            token.kind = TOK_OPEN;
        end else if (char_code == CH_RBRACE) begin
            token.kind = TOK_CLOSE;
        end else if (char_code == CH_COMMA) begin
            token.kind = TOK_COMMA;
        end else if (char_code == CH_SPACE) begin
            token.kind = TOK_SPACE;
        end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
            token.kind = TOK_DIGIT;
        end else begin
            token.kind = TOK_OTHER;
        end
    end

endmodule

// File: sv/rqp_queue.sv
// Short token queue between front and back, held in flip-flops.
// Depends on rqp_pkg.
module rqp_queue #(
    parameter int DEPTH = rqp_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  rqp_pkg::token_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rqp_pkg::token_t pop_data
);
    import rqp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    token_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/rqp_back.sv
// Back end: quantifier state machine, count accumulators and result register.
// Depends on rqp_pkg.
module rqp_back #(
    parameter int COUNT_WIDTH = rqp_pkg::COUNT_WIDTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            tok_valid,
    output logic            tok_ready,
    input  rqp_pkg::token_t tok,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata,
    output logic [1:0]      m_tuser
);
    import rqp_pkg::*;

    localparam logic [2:0] PH_OPEN      = 3'd0;
    localparam logic [2:0] PH_MIN_LEAD  = 3'd1;
    localparam logic [2:0] PH_MIN_DIG   = 3'd2;
    localparam logic [2:0] PH_MIN_TRAIL = 3'd3;
    localparam logic [2:0] PH_MAX_LEAD  = 3'd4;
    localparam logic [2:0] PH_MAX_DIG   = 3'd5;
    localparam logic [2:0] PH_MAX_TRAIL = 3'd6;

    localparam int WIDE_W = COUNT_WIDTH + 4;

    logic [2:0]             phase_reg, phase_next, ph;
    logic [COUNT_WIDTH-1:0] min_acc_reg, min_acc_next;
    logic [COUNT_WIDTH-1:0] max_acc_reg, max_acc_next;
    logic [COUNT_WIDTH-1:0] acc_sel;
    logic [WIDE_W-1:0]      acc_wide;
    logic                   acc_ovf, in_max;
    logic [2:0]             ph_dig, ph_trail;

    logic                   out_valid_reg;
    status_t                status_reg, status_next;
    logic [OUT_WIDTH-1:0]   min_out_reg, min_out_next;
    logic [OUT_WIDTH-1:0]   max_out_reg, max_out_next;
    logic [COUNT_WIDTH+OUT_WIDTH-1:0] min_ext, max_ext;
    logic                   adv;

    assign adv       = tok_valid && tok_ready;
    assign tok_ready = !out_valid_reg || m_tready;

    // Unused phase codes behave as expecting the opening brace.
    always_comb begin
        unique case (phase_reg) inside
            PH_OPEN, PH_MIN_LEAD, PH_MIN_DIG, PH_MIN_TRAIL,
            PH_MAX_LEAD, PH_MAX_DIG, PH_MAX_TRAIL: ph = phase_reg;
            default:                               ph = PH_OPEN;
        endcase
    end

    assign in_max   = (ph >= PH_MAX_LEAD);
    assign ph_dig   = in_max ? PH_MAX_DIG : PH_MIN_DIG;
    assign ph_trail = in_max ? PH_MAX_TRAIL : PH_MIN_TRAIL;
    assign acc_sel  = in_max ? max_acc_reg : min_acc_reg;

    // acc * 10 + digit as (acc << 3) + (acc << 1) + digit; overflow when the
    // extra top bits are set.
    assign acc_wide = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                    + {{COUNT_WIDTH{1'b0}}, tok.digit};
    assign acc_ovf  = |acc_wide[WIDE_W-1:COUNT_WIDTH];

    assign min_ext = {{OUT_WIDTH{1'b0}}, min_acc_reg};
    assign max_ext = {{OUT_WIDTH{1'b0}}, max_acc_reg};

    always_comb begin
        phase_next   = phase_reg;
        min_acc_next = min_acc_reg;
        max_acc_next = max_acc_reg;
        status_next  = ST_PENDING;
        min_out_next = '0;
        max_out_next = '0;
        if (tok.kind == TOK_EOT) begin
            phase_next  = PH_OPEN;
            status_next = (ph == PH_OPEN) ? ST_PENDING : ST_ERROR;
        end else if (ph == PH_OPEN) begin
            if (tok.kind == TOK_OPEN) begin
                min_acc_next = '0;
                max_acc_next = '0;
                phase_next   = PH_MIN_LEAD;
            end else begin
                status_next = ST_ERROR;
            end
        end else begin
            case (tok.kind)
                TOK_SPACE: begin
                    if (ph == ph_dig) begin
                        phase_next = ph_trail;
                    end
                end
                TOK_DIGIT: begin
                    if (ph == ph_trail || acc_ovf) begin
                        phase_next  = PH_OPEN;
                        status_next = ST_ERROR;
                    end else begin
                        phase_next = ph_dig;
                        if (in_max) begin
                            max_acc_next = acc_wide[COUNT_WIDTH-1:0];
                        end else begin
                            min_acc_next = acc_wide[COUNT_WIDTH-1:0];
                        end
                    end
                end
                TOK_COMMA: begin
                    if (in_max) begin
                        phase_next  = PH_OPEN;
                        status_next = ST_ERROR;
                    end else begin
                        phase_next = PH_MAX_LEAD;
                    end
                end
                TOK_CLOSE: begin
                    phase_next   = PH_OPEN;
                    status_next  = ST_ACCEPT;
                    min_out_next = min_ext[OUT_WIDTH-1:0];
                    max_out_next = in_max ? max_ext[OUT_WIDTH-1:0] : min_ext[OUT_WIDTH-1:0];
                end
                default: begin
                    phase_next  = PH_OPEN;
                    status_next = ST_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_OPEN;
            min_acc_reg   <= '0;
            max_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                phase_reg   <= phase_next;
                min_acc_reg <= min_acc_next;
                max_acc_reg <= max_acc_next;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            status_reg  <= status_next;
            min_out_reg <= min_out_next;
            max_out_reg <= max_out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {max_out_reg, min_out_reg};
    assign m_tuser  = status_reg;

endmodule

// File: sv/repeat_quantifier_parser.sv
// Repeat quantifier parser: parses '{' [min] [',' [max]] '}' one character per word.
// A word passes through the queue, then the result register, before its result shows.
// Throughput: one word per cycle while m_tready takes results; the back end does its
// state update and the times-ten add on the count together.
// Reset: synchronous aresetn (active low) empties the queue and result register and
// returns the parser to expecting '{' with both counts zero.
module repeat_quantifier_parser #(
    parameter int COUNT_WIDTH = rqp_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [0:0]  s_tuser,   // [0] end_of_text
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] min_count, [63:32] max_count
    output logic [1:0]  m_tuser    // [1:0] parse_status
);
    import rqp_pkg::*;

    token_t front_tok;
    token_t back_tok;
    logic   back_valid;
    logic   back_ready;

    // Classify the incoming character; no state in the front end.
    rqp_front u_front (
        .char_code   (s_tdata),
        .end_of_text (s_tuser[0]),
        .token       (front_tok)
    );

    // Hold classified tokens until the back end takes them; the front end
    // stalls only when this queue is full.
    rqp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (front_tok),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_tok)
    );

    // Advance the quantifier state machine and register one result per token.
    rqp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (back_valid),
        .tok_ready (back_ready),
        .tok       (back_tok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: sv/rqp_checker.sv
// Port-level checker for the repeat quantifier parser, bound to the top level.
// Depends on rqp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rqp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import rqp_pkg::*;

    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_counts_zero, aclk, aresetn, (m_tvalid && m_tuser != ST_ACCEPT) |-> (m_tdata == 64'd0), "counts nonzero on non-accept result")
    `ASSERT_CLK(a_stall_only_backed_up, aclk, aresetn, !s_tready |-> m_tvalid, "input stalled with no result pending")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind repeat_quantifier_parser rqp_checker u_rqp_checker (.*);
